[sv/vcs_pkg.sv]
// Package for the vector cosine similarity block.
// Holds widths, controller commands and status types; no dependencies.
`default_nettype none
package vcs_pkg;
  localparam int ELEM_W    = 16;
  localparam int NORM_W    = 41;
  localparam int DOT_W     = NORM_W + 1;
  localparam int MAG_W     = DOT_W;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int OUT_FRAC  = 15;
  localparam int OUT_W     = OUT_FRAC + 1;
  localparam int WIDE_W    = PROD_W + 2 * OUT_FRAC + 2;
  localparam int MUL_STEPS = MAG_W;
  localparam int CNT_W     = 6;

  typedef struct packed {
    logic acc_en;
    logic mul_step;
    logic sq_init;
    logic sq_add;
    logic sq_cmp;
    logic out_load;
  } vcs_cmd_t;

  typedef struct packed {
    logic zero_nxt;
    logic out_free;
  } vcs_stat_t;
endpackage
`default_nettype wire

[sv/vector_cosine_similarity.sv]
// After the last item the result passes multiply, root init, root search, output load and
// the output register; on zero norm it goes straight to output load and the output register.
// Throughput: one item per cycle while accumulating; the 42-step shift-add multipliers and
// the 16-step bit-serial root search hold off input after each last item (only the output
// load does on zero norm), longer while the previous result waits on out_tready.
// Reset: rst_n synchronous active low clears sums, state and output valid.
// Top level joining vcs_ctrl and vcs_dp; depends on vcs_pkg.
`default_nettype none
module vector_cosine_similarity import vcs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [2*ELEM_W-1:0] in_tdata,   // elem_a, elem_b
  input  wire logic                in_tlast,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_W-1:0]         out_tdata,  // similarity
  output logic                     out_tuser   // zero_norm
);
  vcs_cmd_t  cmd;
  vcs_stat_t stat;

  vcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  vcs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .elem_a     (signed'(in_tdata[ELEM_W-1:0])),
    .elem_b     (signed'(in_tdata[2*ELEM_W-1:ELEM_W])),
    .elem_last  (in_tlast),
    .out_tready (out_tready),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_sim    (out_tdata),
    .out_zero   (out_tuser)
  );
endmodule
`default_nettype wire

[sv/vcs_dp.sv]
// Datapath: accumulators, shift-add multipliers, bit-serial root/divide, output register.
// Depends on vcs_pkg; driven by vcs_ctrl commands.
`default_nettype none
module vcs_dp import vcs_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire vcs_cmd_t                 cmd,
  input  wire logic signed [ELEM_W-1:0] elem_a,
  input  wire logic signed [ELEM_W-1:0] elem_b,
  input  wire logic                     elem_last,
  input  wire logic                     out_tready,
  output vcs_stat_t                     stat,
  output logic                          out_valid,
  output logic [OUT_W-1:0]              out_sim,
  output logic                          out_zero
);
  logic [NORM_W-1:0]        na_r, nb_r, na_nxt, nb_nxt;
  logic signed [DOT_W-1:0]  dot_r, dot_nxt;
  logic signed [2*ELEM_W-1:0] p_ab, p_aa, p_bb;
  logic [NORM_W:0]          na_sum, nb_sum;
  logic signed [DOT_W:0]    dot_sum;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        ma_r, p_r, mm_r, m_r;
  logic [MAG_W-1:0]         mb_r, mmb_r;
  logic [WIDE_W-1:0]        x_r, y_r, s_r, r_r, t_r;
  logic [OUT_W-1:0]         q_r, mask_r, sim_r;
  logic                     neg_r, zero_r, valid_r, zero_out_r;
  logic                     take;

  assign p_ab = elem_a * elem_b;
  assign p_aa = elem_a * elem_a;
  assign p_bb = elem_b * elem_b;
  assign na_sum = (NORM_W+1)'(na_r) + (NORM_W+1)'(unsigned'(p_aa));
  assign nb_sum = (NORM_W+1)'(nb_r) + (NORM_W+1)'(unsigned'(p_bb));
  assign dot_sum = (DOT_W+1)'(dot_r) + (DOT_W+1)'(p_ab);

  always_comb begin
    na_nxt = na_sum[NORM_W] ? {NORM_W{1'b1}} : na_sum[NORM_W-1:0];
    nb_nxt = nb_sum[NORM_W] ? {NORM_W{1'b1}} : nb_sum[NORM_W-1:0];
    if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
      dot_nxt = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_nxt = dot_sum[DOT_W-1:0];
    end
    mag = dot_nxt[DOT_W-1] ? MAG_W'(-dot_nxt) : MAG_W'(dot_nxt);
  end

  assign stat.zero_nxt = (na_nxt == '0) || (nb_nxt == '0);
  assign stat.out_free = !valid_r || out_tready;
  assign take = (t_r <= r_r) && !q_r[OUT_FRAC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      na_r  <= '0;
      nb_r  <= '0;
      dot_r <= '0;
    end else if (cmd.acc_en) begin
      if (elem_last) begin
        na_r  <= '0;
        nb_r  <= '0;
        dot_r <= '0;
      end else begin
        na_r  <= na_nxt;
        nb_r  <= nb_nxt;
        dot_r <= dot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && elem_last) begin
      ma_r   <= PROD_W'(na_nxt);
      mb_r   <= MAG_W'(nb_nxt);
      p_r    <= '0;
      mm_r   <= PROD_W'(mag);
      mmb_r  <= mag;
      m_r    <= '0;
      neg_r  <= dot_nxt[DOT_W-1];
      zero_r <= stat.zero_nxt;
    end else if (cmd.mul_step) begin
      p_r   <= p_r + (mb_r[0] ? ma_r : '0);
      ma_r  <= ma_r << 1;
      mb_r  <= mb_r >> 1;
      m_r   <= m_r + (mmb_r[0] ? mm_r : '0);
      mm_r  <= mm_r << 1;
      mmb_r <= mmb_r >> 1;
    end
    if (cmd.sq_init) begin
      y_r    <= WIDE_W'(p_r) << (2 * OUT_FRAC);
      r_r    <= WIDE_W'(m_r) << (2 * OUT_FRAC);
      x_r    <= '0;
      s_r    <= '0;
      q_r    <= '0;
      mask_r <= OUT_W'(1) << OUT_FRAC;
    end else if (cmd.sq_add) begin
      t_r <= s_r + x_r + y_r;
    end else if (cmd.sq_cmp) begin
      if (take) begin
        s_r <= t_r;
        q_r <= q_r | mask_r;
        x_r <= (x_r >> 1) + y_r;
      end else begin
        x_r <= x_r >> 1;
      end
      y_r    <= y_r >> 2;
      mask_r <= mask_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      zero_out_r <= zero_r;
      if (zero_r) begin
        sim_r <= '0;
      end else if (neg_r) begin
        sim_r <= -q_r;
      end else if (q_r[OUT_FRAC]) begin
        sim_r <= {1'b0, {OUT_FRAC{1'b1}}};
      end else begin
        sim_r <= q_r;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_sim   = sim_r;
  assign out_zero  = zero_out_r;
endmodule
`default_nettype wire

[sv/vcs_ctrl.sv]
// Controller state machine: sequences accumulate, multiply, root search and output.
// Depends on vcs_pkg; drives vcs_dp.
`default_nettype none
module vcs_ctrl import vcs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      in_tlast,
  input  wire vcs_stat_t stat,
  output logic           in_tready,
  output vcs_cmd_t       cmd
);
  localparam logic [2:0] S_ACC  = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_ACC);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_ACC: begin
        if (in_tvalid) begin
          cmd.acc_en = 1'b1;
          if (in_tlast) begin
            cnt_nxt   = '0;
            state_nxt = stat.zero_nxt ? S_FIN : S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.sq_init = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_ADD;
      end
      S_ADD: begin
        cmd.sq_add = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.sq_cmp = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        state_nxt  = (cnt_r == CNT_W'(OUT_FRAC)) ? S_FIN : S_ADD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_load_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == S_ACC) else $error("no return to accumulate");
  a_init_add: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |=> state_r == S_ADD && cnt_r == '0) else $error("bad init");
  a_add_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |=> state_r == S_CMP) else $error("add not followed by compare");
`endif
endmodule
`default_nettype wire
